[rtl/core/string_hash_set_lookup_assert.svh]
// Assertion macros shared by the string hash set lookup RTL.
`ifndef STRING_HASH_SET_LOOKUP_ASSERT_SVH
`define STRING_HASH_SET_LOOKUP_ASSERT_SVH

// Plain property, sampled on clk_i, off during reset.
`define SHSL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Overlapping implication, sampled on clk_i, off during reset.
`define SHSL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/core/shsl_pkg.sv]
// Shared types and constants of the string hash set lookup block.
package shsl_pkg;

  localparam int HASH_W          = 32;
  localparam int BYTE_W          = 8;
  localparam logic [HASH_W-1:0] SEED_RESET = 32'd131;

  localparam int NUM_BUCKETS_DEF = 4093;
  localparam int WAYS_DEF        = 8;

  // bucket remainder: bits of the hash consumed per cycle
  localparam int MOD_BITS  = 4;
  localparam int MOD_ITERS = HASH_W / MOD_BITS;
  localparam int MOD_CNT_W = $clog2(MOD_ITERS);

  typedef struct packed {
    logic clr;
    logic fold;
    logic mod_start;
    logic mod_step;
    logic fill_rd;
    logic exec;
    logic scan;
    logic load_out;
  } shsl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic mod_done;
    logic lookup;
    logic scan_done;
  } shsl_sts_t;

endpackage

[rtl/core/shsl_dp.sv]
// Datapath: hash fold, bucket remainder, fill counts, entry store and result register.
`include "string_hash_set_lookup_assert.svh"

module shsl_dp #(
  parameter int NUM_BUCKETS = shsl_pkg::NUM_BUCKETS_DEF,
  parameter int WAYS        = shsl_pkg::WAYS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [shsl_pkg::HASH_W-1:0]   cfg_wdata_i,
  input  logic                          func_i,
  input  logic [shsl_pkg::BYTE_W-1:0]   data_byte_i,
  input  logic                          last_byte_i,
  input  shsl_pkg::shsl_cmd_t           cmd_i,
  output shsl_pkg::shsl_sts_t           sts_o,
  output logic                          found_o,
  output logic                          bucket_full_o,
  output logic [shsl_pkg::HASH_W-1:0]   string_hash_o
);

  localparam int HW     = shsl_pkg::HASH_W;
  localparam int BW     = shsl_pkg::BYTE_W;
  localparam int BKT_W  = $clog2(NUM_BUCKETS);
  localparam int RW     = BKT_W + 1;
  localparam int FILL_W = $clog2(WAYS + 1);
  localparam int AW     = $clog2(NUM_BUCKETS * WAYS);
  localparam int CW     = shsl_pkg::MOD_CNT_W;

  logic [HW-1:0]     seed_q;
  logic [HW-1:0]     acc_q;
  logic [HW-1:0]     ext_byte;
  logic [HW-1:0]     hash_next;
  logic [HW-1:0]     hash_q;
  logic              func_q;
  logic [HW-1:0]     sh_q;
  logic [BKT_W-1:0]  rem_q;
  logic [BKT_W-1:0]  rem_next;
  logic [RW-1:0]     mod_r;
  logic [CW-1:0]     mod_cnt_q;
  logic [BKT_W-1:0]  clr_idx_q;
  logic [FILL_W-1:0] fill_rd_q;
  logic [AW-1:0]     ent_addr_q;
  logic [FILL_W-1:0] way_q;
  logic [HW-1:0]     ent_q;
  logic              ent_vld_q;
  logic              found_q;
  logic              full_q;
  logic              out_found_q;
  logic              out_full_q;
  logic [HW-1:0]     out_hash_q;
  logic              issue;
  logic              hit;
  logic              ins_we;
  logic              fill_we;
  logic [BKT_W-1:0]  fill_waddr;
  logic [FILL_W-1:0] fill_wdata;

  logic [FILL_W-1:0] fill_mem [NUM_BUCKETS];
  logic [HW-1:0]     ent_mem  [NUM_BUCKETS * WAYS];

  // fold: hash * seed + sign-extended byte, mod 2^32
  assign ext_byte  = {{(HW-BW){data_byte_i[BW-1]}}, data_byte_i};
  assign hash_next = acc_q * seed_q + ext_byte;

  // restoring remainder, MOD_BITS hash bits per cycle
  always_comb begin
    mod_r = {1'b0, rem_q};
    for (int i = 0; i < shsl_pkg::MOD_BITS; i++) begin
      mod_r = {mod_r[BKT_W-1:0], sh_q[HW-1-i]};
      if (mod_r >= RW'(NUM_BUCKETS)) begin
        mod_r = mod_r - RW'(NUM_BUCKETS);
      end
    end
    rem_next = mod_r[BKT_W-1:0];
  end

  assign issue  = way_q < fill_rd_q;
  assign hit    = ent_vld_q && (ent_q == hash_q);
  assign ins_we = cmd_i.exec && !func_q && (fill_rd_q < FILL_W'(WAYS));

  assign fill_we    = cmd_i.clr || ins_we;
  assign fill_waddr = cmd_i.clr ? clr_idx_q : rem_q;
  assign fill_wdata = cmd_i.clr ? '0 : fill_rd_q + FILL_W'(1);

  assign sts_o.clr_done  = clr_idx_q == BKT_W'(NUM_BUCKETS - 1);
  assign sts_o.mod_done  = mod_cnt_q == CW'(shsl_pkg::MOD_ITERS - 1);
  assign sts_o.lookup    = func_q;
  assign sts_o.scan_done = hit || found_q || (!issue && !ent_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q    <= shsl_pkg::SEED_RESET;
      acc_q     <= '0;
      clr_idx_q <= '0;
      mod_cnt_q <= '0;
      way_q     <= '0;
      ent_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
      if (cmd_i.fold) begin
        acc_q <= last_byte_i ? '0 : hash_next;
      end
      if (cmd_i.clr && !sts_o.clr_done) begin
        clr_idx_q <= clr_idx_q + BKT_W'(1);
      end
      if (cmd_i.mod_start) begin
        mod_cnt_q <= '0;
      end else if (cmd_i.mod_step) begin
        mod_cnt_q <= mod_cnt_q + CW'(1);
      end
      if (cmd_i.exec) begin
        way_q     <= '0;
        ent_vld_q <= 1'b0;
      end else if (cmd_i.scan) begin
        ent_vld_q <= issue;
        if (issue) begin
          way_q <= way_q + FILL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mod_start) begin
      hash_q <= hash_next;
      func_q <= func_i;
      sh_q   <= hash_next;
      rem_q  <= '0;
    end else if (cmd_i.mod_step) begin
      sh_q  <= sh_q << shsl_pkg::MOD_BITS;
      rem_q <= rem_next;
    end
    if (cmd_i.fill_rd) begin
      ent_addr_q <= AW'(rem_q) * AW'(WAYS);
    end else if (cmd_i.scan && issue) begin
      ent_addr_q <= ent_addr_q + AW'(1);
    end
    if (cmd_i.exec) begin
      found_q <= 1'b0;
      full_q  <= !func_q && (fill_rd_q >= FILL_W'(WAYS));
    end else if (cmd_i.scan) begin
      found_q <= found_q || hit;
    end
    if (cmd_i.load_out) begin
      out_found_q <= found_q;
      out_full_q  <= full_q;
      out_hash_q  <= hash_q;
    end
  end

  // bucket fill counts
  always_ff @(posedge clk_i) begin
    if (fill_we) begin
      fill_mem[fill_waddr] <= fill_wdata;
    end
    if (cmd_i.fill_rd) begin
      fill_rd_q <= fill_mem[rem_q];
    end
  end

  // stored hashes
  always_ff @(posedge clk_i) begin
    if (ins_we) begin
      ent_mem[ent_addr_q + AW'(fill_rd_q)] <= hash_q;
    end
    if (cmd_i.scan && issue) begin
      ent_q <= ent_mem[ent_addr_q];
    end
  end

  assign found_o       = out_found_q;
  assign bucket_full_o = out_full_q;
  assign string_hash_o = out_hash_q;

  `SHSL_ASSERT_IMP(a_bucket_range, cmd_i.fill_rd, {1'b0, rem_q} < RW'(NUM_BUCKETS),
                   "bucket index out of range")
  `SHSL_ASSERT(a_fill_bound, !cmd_i.exec || (fill_rd_q <= FILL_W'(WAYS)),
               "bucket fill count above way count")
  `SHSL_ASSERT_IMP(a_clr_hold, cmd_i.clr && !sts_o.clr_done, $stable(seed_q) || $past(cfg_we_i),
                   "seed changed without a configuration write")

endmodule

[rtl/core/shsl_ctrl.sv]
// Controller state machine: clear pass, byte acceptance, remainder, insert or lookup, result.
`include "string_hash_set_lookup_assert.svh"

module shsl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                last_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  shsl_pkg::shsl_sts_t sts_i,
  output shsl_pkg::shsl_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_MOD   = 7'b0000100,
    ST_FILL  = 7'b0001000,
    ST_EXEC  = 7'b0010000,
    ST_SCAN  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   out_valid_q;
  logic   out_valid_d;
  logic   in_acc;

  assign in_ready_o = state_q == ST_IDLE;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          cmd_o.fold = 1'b1;
          if (last_byte_i) begin
            cmd_o.mod_start = 1'b1;
            state_d         = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_done) begin
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        cmd_o.fill_rd = 1'b1;
        state_d       = ST_EXEC;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.lookup ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `SHSL_ASSERT_IMP(a_no_overwrite, cmd_o.load_out, !out_valid_q || out_ready_i,
                   "result register overwritten before transaction")
  `SHSL_ASSERT_IMP(a_last_starts_mod, in_acc && last_byte_i, ##1 state_q == ST_MOD,
                   "final byte did not start bucket selection")
  `SHSL_ASSERT_IMP(a_scan_is_lookup, cmd_o.scan, sts_i.lookup,
                   "way scan on an insert")

endmodule

[rtl/core/string_hash_set_lookup.sv]
// Top level of the string hash set lookup block.
// Input channel (in_valid_i/in_ready_o): one string byte per transaction with
// func_i (0 insert, 1 lookup, sampled on the final byte) and last_byte_i.
// Bytes fold into a 32-bit hash (hash * seed + signed byte). A final byte
// selects bucket = hash mod NUM_BUCKETS (4 hash bits per cycle) and reads
// the bucket fill count; then an insert writes one way, or flags
// bucket_full_o if the bucket is full, while a lookup reads the filled ways
// one per cycle from the entry memory, stopping at the first match. One
// result transaction (out_valid_o/out_ready_i) follows each final byte.
// cfg_we_i writes the hash seed (reset 131); write it only while idle.
// After reset the bucket fill counts are cleared, one bucket per cycle, and
// in_ready_o stays low meanwhile.
// A finished result waits in an output register; bytes of the next string
// are accepted while it is stalled, and the block holds only when a further
// result is ready before the previous one is taken.
module string_hash_set_lookup #(
  parameter int NUM_BUCKETS = shsl_pkg::NUM_BUCKETS_DEF,
  parameter int WAYS        = shsl_pkg::WAYS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [shsl_pkg::HASH_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        func_i,
  input  logic [shsl_pkg::BYTE_W-1:0] data_byte_i,
  input  logic                        last_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        found_o,
  output logic                        bucket_full_o,
  output logic [shsl_pkg::HASH_W-1:0] string_hash_o
);

  shsl_pkg::shsl_cmd_t cmd;
  shsl_pkg::shsl_sts_t sts;

  shsl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .last_byte_i (last_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  shsl_dp #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .WAYS        (WAYS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .func_i        (func_i),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .found_o       (found_o),
    .bucket_full_o (bucket_full_o),
    .string_hash_o (string_hash_o)
  );

endmodule

[tb/tb_top.sv]
// Self-checking testbench for string_hash_set_lookup: scored against a hash set predictor.
module tb_top;

  localparam int HASH_W         = shsl_pkg::HASH_W;
  localparam int BYTE_W         = shsl_pkg::BYTE_W;
  localparam logic [HASH_W-1:0] SEED_RESET = shsl_pkg::SEED_RESET;
  localparam int NUM_BUCKETS    = shsl_pkg::NUM_BUCKETS_DEF;
  localparam int WAYS           = shsl_pkg::WAYS_DEF;
  localparam int MAX_LEN        = 12;
  localparam int IDLE_LIMIT     = 20000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int POOL_DEPTH     = 24;
  localparam logic FUNC_INSERT  = 1'b0;
  localparam logic FUNC_LOOKUP  = 1'b1;
  localparam logic [HASH_W-1:0] SEED_COLLIDE = 32'd4093;

  typedef struct packed {
    logic [MAX_LEN*8-1:0] text;
    logic [4:0]           len;
  } str_t;

  typedef struct packed {
    logic              found;
    logic              bucket_full;
    logic [HASH_W-1:0] string_hash;
  } hash_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [HASH_W-1:0] cfg_wdata_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              func_i;
  logic [BYTE_W-1:0] data_byte_i;
  logic              last_byte_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              found_o;
  logic              bucket_full_o;
  logic [HASH_W-1:0] string_hash_o;

  // predictor state
  logic [HASH_W-1:0] cur_seed = SEED_RESET;
  logic [HASH_W-1:0] run_hash = '0;
  logic [HASH_W-1:0] set_entries [NUM_BUCKETS*WAYS];
  int unsigned       set_fill [NUM_BUCKETS];
  hash_result_t      pending_results [$];

  str_t str_pool [$];
  int   bytes_sent = 0;
  int   mismatch_count = 0;
  int   idle_cycles = 0;
  int   tx_seg_left = 0;
  bit   tx_steady = 1'b0;
  bit   rx_hold_req = 1'b0;

  string_hash_set_lookup #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .WAYS       (WAYS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .found_o      (found_o),
    .bucket_full_o(bucket_full_o),
    .string_hash_o(string_hash_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int tx_gap();
    if (tx_seg_left == 0) begin
      tx_seg_left = $urandom_range(20, 120);
      tx_steady   = ($urandom_range(0, 3) == 0);
    end
    tx_seg_left--;
    return tx_steady ? 0 : pick_gap();
  endfunction

  function automatic str_t rand_string();
    str_t s;
    s.text = {$urandom(), $urandom(), $urandom()};
    s.len  = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(9, MAX_LEN))
                                          : 5'($urandom_range(1, 6));
    return s;
  endfunction

  function automatic str_t one_byte(input logic [7:0] b0);
    str_t s;
    s = '0;
    s.text[7:0] = b0;
    s.len = 5'd1;
    return s;
  endfunction

  function automatic str_t pair_string(input logic [7:0] b0, input logic [7:0] b1);
    str_t s;
    s = '0;
    s.text[15:0] = {b1, b0};
    s.len = 5'd2;
    return s;
  endfunction

  // fold one byte; on the final byte, update the set and queue the result
  task automatic fold_and_lookup(input logic f, input logic [7:0] b, input logic l);
    logic [HASH_W-1:0] h;
    int unsigned       bkt;
    int unsigned       fill;
    hash_result_t      r;
    h = run_hash * cur_seed + {{24{b[7]}}, b};
    if (!l) begin
      run_hash = h;
      return;
    end
    run_hash = '0;
    bkt  = h % NUM_BUCKETS;
    fill = set_fill[bkt];
    r = '0;
    r.string_hash = h;
    if (f == FUNC_INSERT) begin
      if (fill >= WAYS) begin
        r.bucket_full = 1'b1;
      end else begin
        set_entries[bkt*WAYS+fill] = h;
        set_fill[bkt] = fill + 1;
      end
    end else begin
      for (int w = 0; w < fill; w++)
        if (set_entries[bkt*WAYS+w] == h) r.found = 1'b1;
    end
    pending_results.push_back(r);
  endtask

  task automatic send_byte(input logic f, input logic [7:0] b, input logic l);
    int gap;
    gap = tx_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    func_i      <= f;
    data_byte_i <= b;
    last_byte_i <= l;
    do @(posedge clk_i); while (!in_ready_o);
    fold_and_lookup(f, b, l);
    bytes_sent++;
  endtask

  // func on non-final bytes is don't-care, so randomize it
  task automatic send_string(input logic f, input str_t s);
    for (int i = 0; i < s.len; i++)
      send_byte((i == s.len - 1) ? f : 1'($urandom_range(0, 1)), s.text[i*8 +: 8],
                i == s.len - 1);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_seed(input logic [HASH_W-1:0] seed);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= seed;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_seed = seed;
    str_pool.delete();
  endtask

  task automatic report_mismatch(input string what, input logic [HASH_W-1:0] got,
                                 input logic [HASH_W-1:0] exp_val);
    $display("ERROR @%0t %s: got %h expected %h", $time, what, got, exp_val);
    mismatch_count++;
  endtask

  task automatic test_byte_extremes();
    str_t s;
    send_string(FUNC_INSERT, one_byte(8'h00));
    send_string(FUNC_INSERT, one_byte(8'hFF));
    send_string(FUNC_LOOKUP, one_byte(8'hFF));
    send_string(FUNC_LOOKUP, one_byte(8'h7F));
    send_string(FUNC_INSERT, one_byte(8'h80));
    send_string(FUNC_LOOKUP, one_byte(8'h80));
    s = '0;
    s.text[23:0] = {8'hFF, 8'h80, 8'h7F};
    s.len = 5'd3;
    send_string(FUNC_INSERT, s);
    send_string(FUNC_LOOKUP, s);
  endtask

  // duplicates fill every way, the ninth insert is dropped
  task automatic test_full_bucket();
    repeat (WAYS + 1) send_string(FUNC_INSERT, one_byte(8'h41));
    send_string(FUNC_LOOKUP, one_byte(8'h41));
  endtask

  // zero seed: only the final byte matters
  task automatic test_zero_seed();
    set_seed('0);
    send_string(FUNC_INSERT, pair_string(8'h12, 8'h34));
    send_string(FUNC_LOOKUP, pair_string(8'h56, 8'h34));
  endtask

  task automatic test_random_strings(input int nbytes);
    int   start;
    int   r;
    str_t s;
    start = bytes_sent;
    while (bytes_sent - start < nbytes) begin
      r = $urandom_range(0, 99);
      if (r < 35 || str_pool.size() == 0) begin
        s = rand_string();
        send_string(FUNC_INSERT, s);
        str_pool.push_back(s);
        if (str_pool.size() > POOL_DEPTH) void'(str_pool.pop_front());
      end else if (r < 55) begin
        send_string(FUNC_LOOKUP, str_pool[$urandom_range(0, str_pool.size() - 1)]);
      end else if (r < 70) begin
        send_string(FUNC_LOOKUP, rand_string());
      end else if (r < 85) begin
        send_string(FUNC_INSERT, str_pool[$urandom_range(0, str_pool.size() - 1)]);
      end else begin
        send_string(1'($urandom_range(0, 1)), rand_string());
      end
    end
  endtask

  // seed 4093 and a small positive first byte: bucket is the second byte,
  // so distinct hashes pile into one bucket
  task automatic test_bucket_collisions(input int nbytes);
    int         start;
    logic [7:0] tag;
    start = bytes_sent;
    tag = 8'($urandom_range(0, 127));
    while (bytes_sent - start < nbytes) begin
      if ($urandom_range(0, 19) == 0) tag = 8'($urandom_range(0, 127));
      send_string(1'($urandom_range(0, 1)), pair_string(8'($urandom_range(1, 16)), tag));
    end
  endtask

  // receiver stalls while short strings keep coming
  task automatic test_output_stall();
    rx_hold_req = 1'b1;
    repeat (30) send_string(1'($urandom_range(0, 1)), one_byte(8'($urandom_range(0, 255))));
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    func_i      = 1'b0;
    data_byte_i = '0;
    last_byte_i = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_byte_extremes();
    test_full_bucket();
    test_zero_seed();
    set_seed(32'd1);
    test_random_strings(250);
    set_seed(32'hFFFF_FFFF);
    test_random_strings(250);
    set_seed(SEED_COLLIDE);
    test_bucket_collisions(250);
    set_seed(32'd31);
    test_output_stall();
    test_random_strings(250);
    set_seed($urandom());
    test_random_strings(250);
    set_seed(32'd1313);
    test_random_strings(250);
    set_seed(SEED_RESET);
    test_random_strings(200);

    drain();
    if (mismatch_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    int rx_seg_left;
    int rx_gap_left;
    bit rx_steady;
    rx_seg_left = 0;
    rx_gap_left = 0;
    rx_steady   = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk_i);
      end
      if (rx_seg_left == 0) begin
        rx_seg_left = $urandom_range(20, 200);
        rx_steady   = ($urandom_range(0, 2) == 0);
      end
      rx_seg_left--;
      if (rx_gap_left > 0) begin
        out_ready_i <= 1'b0;
        rx_gap_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (!rx_steady) rx_gap_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    hash_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with none pending", string_hash_o, '0);
      end else begin
        exp_r = pending_results.pop_front();
        if (found_o !== exp_r.found)
          report_mismatch("found", HASH_W'(found_o), HASH_W'(exp_r.found));
        if (bucket_full_o !== exp_r.bucket_full)
          report_mismatch("bucket_full", HASH_W'(bucket_full_o), HASH_W'(exp_r.bucket_full));
        if (string_hash_o !== exp_r.string_hash)
          report_mismatch("string_hash", string_hash_o, exp_r.string_hash);
      end
    end
  end

  // no transaction on either side for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else if (rst_ni) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
